### src/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, widths and byte codes of the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int MAX_QUANTITY_BYTES = 4;
   localparam int QTY_W              = 28;
   localparam int QCNT_W             = $clog2(MAX_QUANTITY_BYTES + 1);

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_Q_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_META     = 8'hFF;
   localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE = 4'hD;

   typedef enum logic [2:0] {
      KIND_CHANNEL   = 3'd0,
      KIND_META_HEAD = 3'd1,
      KIND_META_DATA = 3'd2,
      KIND_SYSEX     = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   // One classified input word as it travels through the queue.
   typedef struct packed {
      logic [7:0] track_byte;
      logic       track_start;
      logic       is_cont;
      logic       is_meta;
      logic       is_sysex;
   } qentry_type;

   typedef struct packed {
      kind_type           kind;
      logic [QTY_W-1:0]   delta_time;
      logic [3:0]         event_type;
      logic [3:0]         channel_number;
      logic [7:0]         first_param;
      logic [7:0]         second_param;
      logic [7:0]         meta_type;
      logic [QTY_W-1:0]   meta_length;
      logic [7:0]         data_byte;
      logic               is_last;
   } rsp_type;

   // Program change and channel pressure carry a single data byte.
   function automatic logic one_param(input logic [7:0] status);
      return (status[7:4] == TYPE_PROGRAM) || (status[7:4] == TYPE_PRESSURE);
   endfunction

endpackage

### src/mtep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Valid/ready channels for track bytes in and decoded events out.
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       track_start;

   modport source (output valid, track_byte, track_start, input ready);
   modport sink   (input valid, track_byte, track_start, output ready);
endinterface

interface mtep_rsp_if;
   import mtep_pkg::*;

   logic             valid;
   logic             ready;
   logic [2:0]       kind;
   logic [QTY_W-1:0] delta_time;
   logic [3:0]       event_type;
   logic [3:0]       channel_number;
   logic [7:0]       first_param;
   logic [7:0]       second_param;
   logic [7:0]       meta_type;
   logic [QTY_W-1:0] meta_length;
   logic [7:0]       data_byte;
   logic             is_last;

   modport source (output valid, kind, delta_time, event_type, channel_number,
                   first_param, second_param, meta_type, meta_length, data_byte,
                   is_last, input ready);
   modport sink   (input valid, kind, delta_time, event_type, channel_number,
                   first_param, second_param, meta_type, meta_length, data_byte,
                   is_last, output ready);
endinterface

### src/mtep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Accepts track bytes and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module mtep_front (
   mtep_req_if.sink          req_if,
   input  logic              q_full,
   output logic              q_push,
   output mtep_pkg::qentry_type q_entry
);
   import mtep_pkg::*;

   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

   always_comb begin
      q_entry.track_byte  = req_if.track_byte;
      q_entry.track_start = req_if.track_start;
      q_entry.is_cont     = req_if.track_byte[7];
      q_entry.is_meta     = (req_if.track_byte == BYTE_META);
      q_entry.is_sysex    = (req_if.track_byte == BYTE_SYSEX) ||
                            (req_if.track_byte == BYTE_SYSEX_ESC);
   end

endmodule

### src/mtep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module mtep_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mtep_pkg::qentry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output mtep_pkg::qentry_type pop_data
);
   import mtep_pkg::*;

   qentry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_Q_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_Q_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !valid |-> !pop) else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");
`endif

endmodule

### src/mtep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Decodes delta times, status, channel and meta events, flags sysex and errors; registers results.
// ----------------------------------------------------------------------------
module mtep_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  mtep_pkg::qentry_type q_data,
   output logic                 q_pop,
   mtep_rsp_if.source           rsp_if
);
   import mtep_pkg::*;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_PARAM1,
      PH_PARAM2,
      PH_META_TYPE,
      PH_META_LEN,
      PH_META_DATA
   } phase_type;

   phase_type           phase_ff, phase_in, eff_phase;
   logic [7:0]          running_ff, running_in, eff_running;
   logic [7:0]          current_ff, current_in, eff_current;
   logic [QTY_W-1:0]    delta_ff, delta_in, eff_delta;
   logic [QTY_W-1:0]    length_ff, length_in, eff_length;
   logic [QTY_W-1:0]    remain_ff, remain_in, eff_remain;
   logic [QCNT_W-1:0]   qcnt_ff, qcnt_in, eff_qcnt;
   logic [7:0]          held_param_ff, held_param_in, eff_held_param;
   logic [7:0]          held_meta_ff, held_meta_in, eff_held_meta;
   logic                halted_ff, halted_in, eff_halted;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                emit;
   logic                qty_full;
   logic [QTY_W-1:0]    delta_base;
   logic [7:0]          b;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_if.ready);
   assign b     = q_data.track_byte;

   // A track start clears the whole decoder before its byte is taken.
   always_comb begin
      if (q_data.track_start) begin
         eff_phase      = PH_DELTA;
         eff_running    = '0;
         eff_current    = '0;
         eff_delta      = '0;
         eff_length     = '0;
         eff_remain     = '0;
         eff_qcnt       = '0;
         eff_held_param = '0;
         eff_held_meta  = '0;
         eff_halted     = 1'b0;
      end else begin
         eff_phase      = phase_ff;
         eff_running    = running_ff;
         eff_current    = current_ff;
         eff_delta      = delta_ff;
         eff_length     = length_ff;
         eff_remain     = remain_ff;
         eff_qcnt       = qcnt_ff;
         eff_held_param = held_param_ff;
         eff_held_meta  = held_meta_ff;
         eff_halted     = halted_ff;
      end
   end

   assign qty_full = ((QCNT_W + 1)'(eff_qcnt) + 1'b1) >=
                     (QCNT_W + 1)'(MAX_QUANTITY_BYTES);
   assign delta_base = (eff_qcnt == '0) ? '0 : eff_delta;

   always_comb begin
      phase_in      = phase_ff;
      running_in    = running_ff;
      current_in    = current_ff;
      delta_in      = delta_ff;
      length_in     = length_ff;
      remain_in     = remain_ff;
      qcnt_in       = qcnt_ff;
      held_param_in = held_param_ff;
      held_meta_in  = held_meta_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      rsp_in        = '0;

      if (q_pop) begin
         phase_in      = eff_phase;
         running_in    = eff_running;
         current_in    = eff_current;
         delta_in      = eff_delta;
         length_in     = eff_length;
         remain_in     = eff_remain;
         qcnt_in       = eff_qcnt;
         held_param_in = eff_held_param;
         held_meta_in  = eff_held_meta;
         halted_in     = eff_halted;

         if (!eff_halted) begin
            case (eff_phase)
               PH_DELTA: begin
                  delta_in = {delta_base[QTY_W-8:0], b[6:0]};
                  if (!q_data.is_cont) begin
                     qcnt_in  = '0;
                     phase_in = PH_STATUS;
                  end else if (qty_full) begin
                     halted_in = 1'b1;
                     emit      = 1'b1;
                     rsp_in.kind = KIND_ERROR;
                  end else begin
                     qcnt_in = eff_qcnt + 1'b1;
                  end
               end
               PH_STATUS: begin
                  if (q_data.is_meta) begin
                     phase_in = PH_META_TYPE;
                  end else if (q_data.is_sysex) begin
                     halted_in   = 1'b1;
                     emit        = 1'b1;
                     rsp_in.kind = KIND_SYSEX;
                  end else if (q_data.is_cont) begin
                     running_in = b;
                     current_in = b;
                     phase_in   = PH_PARAM1;
                  end else if (eff_running == '0) begin
                     halted_in   = 1'b1;
                     emit        = 1'b1;
                     rsp_in.kind = KIND_ERROR;
                  end else begin
                     // Running status: this byte is already the first data byte.
                     current_in    = eff_running;
                     held_param_in = b;
                     if (one_param(eff_running)) begin
                        emit                = 1'b1;
                        phase_in            = PH_DELTA;
                        rsp_in.kind         = KIND_CHANNEL;
                        rsp_in.first_param  = b;
                     end else begin
                        phase_in = PH_PARAM2;
                     end
                  end
               end
               PH_PARAM1: begin
                  held_param_in = b;
                  if (one_param(eff_current)) begin
                     emit               = 1'b1;
                     phase_in           = PH_DELTA;
                     rsp_in.kind        = KIND_CHANNEL;
                     rsp_in.first_param = b;
                  end else begin
                     phase_in = PH_PARAM2;
                  end
               end
               PH_PARAM2: begin
                  emit                = 1'b1;
                  phase_in            = PH_DELTA;
                  rsp_in.kind         = KIND_CHANNEL;
                  rsp_in.first_param  = eff_held_param;
                  rsp_in.second_param = b;
               end
               PH_META_TYPE: begin
                  held_meta_in = b;
                  length_in    = '0;
                  qcnt_in      = '0;
                  phase_in     = PH_META_LEN;
               end
               PH_META_LEN: begin
                  length_in = {eff_length[QTY_W-8:0], b[6:0]};
                  if (q_data.is_cont) begin
                     if (qty_full) begin
                        halted_in   = 1'b1;
                        emit        = 1'b1;
                        rsp_in.kind = KIND_ERROR;
                     end else begin
                        qcnt_in = eff_qcnt + 1'b1;
                     end
                  end else begin
                     qcnt_in            = '0;
                     remain_in          = length_in;
                     emit               = 1'b1;
                     rsp_in.kind        = KIND_META_HEAD;
                     rsp_in.meta_type   = eff_held_meta;
                     rsp_in.meta_length = length_in;
                     rsp_in.is_last     = (length_in == '0);
                     phase_in           = (length_in == '0) ? PH_DELTA : PH_META_DATA;
                  end
               end
               PH_META_DATA: begin
                  remain_in          = eff_remain - 1'b1;
                  emit               = 1'b1;
                  rsp_in.kind        = KIND_META_DATA;
                  rsp_in.meta_type   = eff_held_meta;
                  rsp_in.meta_length = eff_length;
                  rsp_in.data_byte   = b;
                  rsp_in.is_last     = (remain_in == '0);
                  if (remain_in == '0) begin
                     phase_in = PH_DELTA;
                  end
               end
               default: begin
                  phase_in = PH_DELTA;
               end
            endcase
         end

         rsp_in.delta_time = delta_in;
         if (rsp_in.kind == KIND_CHANNEL) begin
            rsp_in.event_type     = current_in[7:4];
            rsp_in.channel_number = current_in[3:0];
         end
         if ((rsp_in.kind == KIND_ERROR) || (rsp_in.kind == KIND_SYSEX) ||
             (rsp_in.kind == KIND_CHANNEL)) begin
            rsp_in.is_last = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         running_ff    <= '0;
         current_ff    <= '0;
         delta_ff      <= '0;
         length_ff     <= '0;
         remain_ff     <= '0;
         qcnt_ff       <= '0;
         held_param_ff <= '0;
         held_meta_ff  <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         running_ff    <= running_in;
         current_ff    <= current_in;
         delta_ff      <= delta_in;
         length_ff     <= length_in;
         remain_ff     <= remain_in;
         qcnt_ff       <= qcnt_in;
         held_param_ff <= held_param_in;
         held_meta_ff  <= held_meta_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_ff.kind;
   assign rsp_if.delta_time     = rsp_ff.delta_time;
   assign rsp_if.event_type     = rsp_ff.event_type;
   assign rsp_if.channel_number = rsp_ff.channel_number;
   assign rsp_if.first_param    = rsp_ff.first_param;
   assign rsp_if.second_param   = rsp_ff.second_param;
   assign rsp_if.meta_type      = rsp_ff.meta_type;
   assign rsp_if.meta_length    = rsp_ff.meta_length;
   assign rsp_if.data_byte      = rsp_ff.data_byte;
   assign rsp_if.is_last        = rsp_ff.is_last;

`ifndef SYNTHESIS
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (q_pop && halted_ff && !q_data.track_start) |=> !rsp_valid_ff)
      else $error("result produced while halted");
   a_halt_after_stop: assert property (@(posedge clock) disable iff (reset)
      (q_pop && emit && ((rsp_in.kind == KIND_ERROR) || (rsp_in.kind == KIND_SYSEX)))
      |=> halted_ff) else $error("decoder did not halt after error or sysex");
   a_meta_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_META_DATA) |-> (remain_ff != '0))
      else $error("meta data phase with nothing remaining");
`endif

endmodule

### src/midi_track_event_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Decodes the event stream of a MIDI track chunk, one byte per word.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word carries
//  req_if   in         track_byte, track_start
//  rsp_if   out        kind, delta_time, event/channel, params, meta fields
//
//  One byte is taken per cycle while the queue is not full; a result is
//  presented once its byte has passed from the queue into the output register,
//  and is held there until rsp_if.ready takes it.
//  The four-entry queue lets the input run on while the output is stalled;
//  req_if.ready falls only when the queue is full.
//  Reset is synchronous and leaves the decoder expecting a delta time.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core (
   input  logic        clock,
   input  logic        reset,
   mtep_req_if.sink    req_if,
   mtep_rsp_if.source  rsp_if
);
   import mtep_pkg::*;

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_valid;
   qentry_type q_entry;
   qentry_type q_head;

   mtep_front u_front (
      .req_if  (req_if),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   mtep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_head)
   );

   mtep_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_head),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
